// ===== design/fbm_pkg.sv =====
// package for the forward box mean filter
// types, register codes and defaults shared by all design files
// no dependencies
`default_nettype none
package fbm_pkg;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_WINDOW_DEF = 8;

	localparam int COL_W = 10;
	localparam int ROW_W = 12;
	localparam int FW_W  = 11;
	localparam int FH_W  = 13;
	localparam int WS_W  = 4;
	localparam int SUM_W = 14;
	localparam int CNT_W = 7;
	localparam int CFG_DATA_W = 13;

	localparam logic [FW_W-1:0] FW_RST = 11'd640;
	localparam logic [FH_W-1:0] FH_RST = 13'd480;
	localparam logic [WS_W-1:0] WS_RST = 4'd3;
	localparam logic [FH_W-1:0] FH_MAX = 13'd4096;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_WINDOW_SIZE  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} pix_t;

	typedef struct packed {
		logic [COL_W-1:0] out_col;
		logic [ROW_W-1:0] out_row;
		logic [7:0]       out_red;
		logic [7:0]       out_green;
		logic [7:0]       out_blue;
		logic             run_last;
	} res_t;
endpackage
`default_nettype wire

// ===== design/fbm_store.sv =====
// row store of the box mean filter: one write port, one registered read port
// depends on fbm_pkg
`default_nettype none
module fbm_store
	import fbm_pkg::*;
#(
	parameter int DEPTH = MAX_WINDOW_DEF * MAX_WIDTH_DEF,
	parameter int AW    = $clog2(MAX_WINDOW_DEF * MAX_WIDTH_DEF)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] waddr,
	input  wire pix_t          wdata,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] raddr,
	output pix_t               rdata
);
	pix_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/fbm_div.sv =====
// restoring divider for the three channel sums, one quotient bit per cycle
// depends on fbm_pkg
`default_nettype none
module fbm_div
	import fbm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] sum_r,
	input  wire logic [SUM_W-1:0] sum_g,
	input  wire logic [SUM_W-1:0] sum_b,
	input  wire logic [CNT_W-1:0] cnt,
	output logic                  done,
	output logic [7:0]            q_r,
	output logic [7:0]            q_g,
	output logic [7:0]            q_b
);
	logic [SUM_W-1:0] dvd_q [3];
	logic [CNT_W-1:0] rem_q [3];
	logic [CNT_W-1:0] dsr_q;
	logic [3:0]       step_q;
	logic             busy_q;
	logic [CNT_W:0]   sh   [3];
	logic             ge   [3];
	logic [CNT_W-1:0] rem_n [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sh[k]    = {rem_q[k], dvd_q[k][SUM_W-1]};
			ge[k]    = sh[k] >= {1'b0, dsr_q};
			rem_n[k] = ge[k] ? CNT_W'(sh[k] - {1'b0, dsr_q}) : CNT_W'(sh[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				done   <= 1'b0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				done   <= (step_q == 4'(SUM_W - 1));
				if (step_q == 4'(SUM_W - 1)) begin
					busy_q <= 1'b0;
				end
			end else begin
				done <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q[0] <= sum_r;
			dvd_q[1] <= sum_g;
			dvd_q[2] <= sum_b;
			dsr_q    <= cnt;
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= '0;
			end
		end else if (busy_q) begin
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= rem_n[k];
				dvd_q[k] <= {dvd_q[k][SUM_W-2:0], ge[k]};
			end
		end
	end

	assign q_r = dvd_q[0][7:0];
	assign q_g = dvd_q[1][7:0];
	assign q_b = dvd_q[2][7:0];
endmodule
`default_nettype wire

// ===== design/forward_box_mean_filter.sv =====
// Forward box mean filter. Each accepted pixel is written to the row store; if it
// completes windows, each result is made in turn: one store read per window pixel,
// a drain state, divider start, 14 divider steps and its finish, then emit. Up to
// 64 results per pixel come at the frame corner for an 8x8 window. The single read
// port of the row store and the serial divider set this pace.
// pix_stall stays high until the last result of the pixel is in the output
// register. No clearing pass after reset.
// depends on fbm_pkg, fbm_store, fbm_div
`default_nettype none
module forward_box_mean_filter
	import fbm_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pix_valid,
	output logic                       pix_stall,
	input  wire pix_t                  pix,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output res_t                       res,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int CB    = $clog2(MAX_WIDTH);
	localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int AW    = SW + CB;
	localparam int DEPTH = MAX_WINDOW * (2 ** CB);
	localparam int WLIM  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DRAIN, ST_DSTART, ST_DWAIT, ST_EMIT
	} state_t;

	state_t state_q;
	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;
	logic [WS_W-1:0] ws_q;
	logic [FW_W-1:0] w_eff;
	logic [FH_W-1:0] h_eff;
	logic [WS_W-1:0] n_eff;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [SW-1:0]    slot_q;
	logic [COL_W-1:0] x0_q, x1_q, x_q;
	logic [ROW_W-1:0] y1_q, y_q;
	logic [SW-1:0]    ys_q, js_q;
	logic [2:0]       i_q, j_q;
	logic [SUM_W-1:0] acc_r_q, acc_g_q, acc_b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rd_v_s1;
	res_t             res_q;
	logic             res_valid_q;

	logic             accept;
	logic [FW_W-1:0]  cw;
	logic [FH_W-1:0]  rw;
	logic             col_last, col_ok, row_last, row_ok;
	logic [COL_W-1:0] x0_c;
	logic [ROW_W-1:0] y0_c;
	logic [3:0]       dd, s4, ys0_4;
	logic [SW-1:0]    ys0;
	logic [FW_W-1:0]  wrem;
	logic [FH_W-1:0]  hrem;
	logic [3:0]       ilim, jlim;
	logic             last_i, last_j, last_org;
	logic [SW-1:0]    ys_inc, js_inc, slot_inc;
	logic             wr_en, rd_en;
	logic [AW-1:0]    waddr, raddr;
	pix_t             rdata;
	logic             div_start, div_done;
	logic [7:0]       q_r, q_g, q_b;

	assign cfg_ready = 1'b1;
	assign accept    = pix_valid && !pix_stall;
	assign pix_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		w_eff = (fw_q == '0) ? FW_W'(1) : ((fw_q > FW_W'(WLIM)) ? FW_W'(WLIM) : fw_q);
		h_eff = (fh_q == '0) ? FH_W'(1) : ((fh_q > FH_MAX) ? FH_MAX : fh_q);
		n_eff = (ws_q == '0) ? WS_W'(1) :
			((ws_q > WS_W'(MAX_WINDOW)) ? WS_W'(MAX_WINDOW) : ws_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_RST;
			fh_q <= FH_RST;
			ws_q <= WS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  fw_q <= FW_W'(cfg_data);
				CFG_FRAME_HEIGHT: fh_q <= cfg_data;
				CFG_WINDOW_SIZE:  ws_q <= WS_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// window origins completed by the incoming pixel
	always_comb begin
		cw       = FW_W'(col_q) + FW_W'(1);
		rw       = FH_W'(row_q) + FH_W'(1);
		col_last = (cw == w_eff);
		col_ok   = col_last || ((cw < w_eff) && (cw >= FW_W'(n_eff)));
		row_last = (rw == h_eff);
		row_ok   = row_last || ((rw < h_eff) && (rw >= FH_W'(n_eff)));
		x0_c     = (cw >= FW_W'(n_eff)) ? COL_W'(cw - FW_W'(n_eff)) : '0;
		y0_c     = (rw >= FH_W'(n_eff)) ? ROW_W'(rw - FH_W'(n_eff)) : '0;
		dd       = 4'(row_q - y0_c);
		s4       = 4'(slot_q);
		ys0_4    = (s4 >= dd) ? (s4 - dd) : (s4 + 4'(MAX_WINDOW) - dd);
		ys0      = SW'(ys0_4);
	end

	// clipped window extent at the current origin
	always_comb begin
		wrem     = w_eff - FW_W'(x_q);
		hrem     = h_eff - FH_W'(y_q);
		ilim     = (wrem < FW_W'(n_eff)) ? 4'(wrem) : n_eff;
		jlim     = (hrem < FH_W'(n_eff)) ? 4'(hrem) : n_eff;
		last_i   = ({1'b0, i_q} + 4'd1) == ilim;
		last_j   = ({1'b0, j_q} + 4'd1) == jlim;
		last_org = (x_q == x1_q) && (y_q == y1_q);
		ys_inc   = (ys_q == SW'(MAX_WINDOW - 1)) ? '0 : ys_q + SW'(1);
		js_inc   = (js_q == SW'(MAX_WINDOW - 1)) ? '0 : js_q + SW'(1);
		slot_inc = (slot_q == SW'(MAX_WINDOW - 1)) ? '0 : slot_q + SW'(1);
	end

	assign wr_en     = accept && (FH_W'(col_q) < FH_W'(MAX_WIDTH));
	assign waddr     = {slot_q, CB'(col_q)};
	assign rd_en     = (state_q == ST_SCAN);
	assign raddr     = {js_q, CB'(FW_W'(x_q) + FW_W'(i_q))};
	assign div_start = (state_q == ST_DSTART);

	fbm_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.wr_en (wr_en),
		.waddr (waddr),
		.wdata (pix),
		.rd_en (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	fbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum_r  (acc_r_q),
		.sum_g  (acc_g_q),
		.sum_b  (acc_b_q),
		.cnt    (cnt_q),
		.done   (div_done),
		.q_r    (q_r),
		.q_g    (q_g),
		.q_b    (q_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			slot_q      <= '0;
			rd_v_s1     <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			x0_q        <= '0;
			x1_q        <= '0;
			x_q         <= '0;
			y1_q        <= '0;
			y_q         <= '0;
			ys_q        <= '0;
			js_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			acc_r_q     <= '0;
			acc_g_q     <= '0;
			acc_b_q     <= '0;
			cnt_q       <= '0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN);
			if (rd_v_s1) begin
				acc_r_q <= acc_r_q + SUM_W'(rdata.in_red);
				acc_g_q <= acc_g_q + SUM_W'(rdata.in_green);
				acc_b_q <= acc_b_q + SUM_W'(rdata.in_blue);
				cnt_q   <= cnt_q + CNT_W'(1);
			end
			if (res_valid_q && !res_stall && state_q != ST_EMIT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cw >= w_eff) begin
							col_q <= '0;
							if (rw >= h_eff) begin
								row_q  <= '0;
								slot_q <= '0;
							end else begin
								row_q  <= ROW_W'(rw);
								slot_q <= slot_inc;
							end
						end else begin
							col_q <= COL_W'(cw);
						end
						x0_q    <= x0_c;
						x1_q    <= col_last ? col_q : x0_c;
						x_q     <= x0_c;
						y1_q    <= row_last ? row_q : y0_c;
						y_q     <= y0_c;
						ys_q    <= ys0;
						js_q    <= ys0;
						i_q     <= '0;
						j_q     <= '0;
						acc_r_q <= '0;
						acc_g_q <= '0;
						acc_b_q <= '0;
						cnt_q   <= '0;
						if (col_ok && row_ok) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (last_i) begin
						i_q <= '0;
						if (last_j) begin
							state_q <= ST_DRAIN;
						end else begin
							j_q  <= j_q + 3'd1;
							js_q <= js_inc;
						end
					end else begin
						i_q <= i_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DSTART;
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q     <= 1'b1;
						res_q.out_col   <= x_q;
						res_q.out_row   <= y_q;
						res_q.out_red   <= q_r;
						res_q.out_green <= q_g;
						res_q.out_blue  <= q_b;
						res_q.run_last  <= last_org;
						i_q     <= '0;
						j_q     <= '0;
						acc_r_q <= '0;
						acc_g_q <= '0;
						acc_b_q <= '0;
						cnt_q   <= '0;
						if (last_org) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SCAN;
							if (x_q == x1_q) begin
								x_q  <= x0_q;
								y_q  <= y_q + ROW_W'(1);
								ys_q <= ys_inc;
								js_q <= ys_inc;
							end else begin
								x_q  <= x_q + COL_W'(1);
								js_q <= ys_q;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_res_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_EMIT))
		else $error("result appeared outside emit");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSTART) |-> (cnt_q != '0) && (cnt_q <= CNT_W'(64)))
		else $error("window pixel count out of range");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DWAIT))
		else $error("divider finished outside wait state");

	a_no_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("store read data outside scan");
endmodule
`default_nettype wire

// ===== tb/tb_forward_box_mean_filter.sv =====
// testbench for forward_box_mean_filter: directed table, edge frames, then random frames
// results are checked in order against an internal box mean predictor
// depends on fbm_pkg and the design files
`timescale 1ns / 100ps
module tb;
	import fbm_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 20000;

	typedef struct {
		bit         is_cfg;
		logic [1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		pix_t       p;
		bit         typed;
		res_t       e;
	} step_t;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	pix_t pix;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	forward_box_mean_filter DUT (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [23:0] row_mem [8][1024];
	int pos_col, pos_row;
	int reg_w, reg_h, reg_n;
	res_t mean_q [$];

	int errors, n_pix, n_res, n_cfg;
	bit quiet_send, quiet_recv;
	step_t steps [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_err(input string what, input int got, input int want);
		errors++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	function automatic bit origins(input int pos, input int size, input int n,
			output int lo, output int hi);
		if (pos + 1 == size) begin
			lo = size > n ? size - n : 0;
			hi = size - 1;
			return 1;
		end
		if (pos + 1 < size && pos + 1 >= n) begin
			lo = pos + 1 - n;
			hi = lo;
			return 1;
		end
		return 0;
	endfunction

	// store the pixel, work out the windows it completes, advance the position
	task automatic predict_means(input pix_t p, input bit typed, input res_t e);
		int w, h, n, x0, x1, y0, y1, sr, sg, sb, cnt;
		res_t r;
		res_t run [$];
		bit hx, hy;
		w = reg_w < 1 ? 1 : (reg_w > 1024 ? 1024 : reg_w);
		h = reg_h < 1 ? 1 : (reg_h > 4096 ? 4096 : reg_h);
		n = reg_n < 1 ? 1 : (reg_n > 8 ? 8 : reg_n);
		row_mem[pos_row % 8][pos_col] = p;
		hx = origins(pos_col, w, n, x0, x1);
		hy = origins(pos_row, h, n, y0, y1);
		if (hx && hy) begin
			for (int y = y0; y <= y1; y++) begin
				for (int x = x0; x <= x1; x++) begin
					sr = 0; sg = 0; sb = 0; cnt = 0;
					for (int j = 0; j < n && y + j < h; j++) begin
						for (int i = 0; i < n && x + i < w; i++) begin
							sr += int'(row_mem[(y + j) % 8][x + i][23:16]);
							sg += int'(row_mem[(y + j) % 8][x + i][15:8]);
							sb += int'(row_mem[(y + j) % 8][x + i][7:0]);
							cnt++;
						end
					end
					if (cnt == 0) cnt = 1;
					r.out_col = COL_W'(x);
					r.out_row = ROW_W'(y);
					r.out_red = 8'(sr / cnt);
					r.out_green = 8'(sg / cnt);
					r.out_blue = 8'(sb / cnt);
					r.run_last = 1'b0;
					run.push_back(r);
				end
			end
			run[run.size() - 1].run_last = 1'b1;
		end
		if (typed) mean_q.push_back(e);
		else foreach (run[k]) mean_q.push_back(run[k]);
		if (pos_col + 1 >= w) begin
			pos_col = 0;
			pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
		end else begin
			pos_col = pos_col + 1;
		end
	endtask

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) return 0;
		if (sel < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a falling edge, returns at a falling edge after the transfer
	task automatic send_pix(input pix_t p, input bit typed, input res_t e);
		int gap;
		gap = quiet_send ? 0 : pick_gap();
		if (gap > 0) begin
			pix_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid = 1'b1;
		pix = p;
		do @(posedge clk); while (pix_stall);
		predict_means(p, typed, e);
		n_pix++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
		pix_valid = 1'b0;
		while (mean_q.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		case (idx)
			CFG_FRAME_WIDTH:  reg_w = int'(data[FW_W-1:0]);
			CFG_FRAME_HEIGHT: reg_h = int'(data[FH_W-1:0]);
			CFG_WINDOW_SIZE:  reg_n = int'(data[WS_W-1:0]);
			default: ;
		endcase
		n_cfg++;
	endtask

	function automatic pix_t rand_pix();
		pix_t p;
		p = 24'($urandom);
		if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 1) ? '1 : '0;
		return p;
	endfunction

	task automatic add_cfg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
		step_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.data = data;
		steps.push_back(s);
	endtask

	task automatic add_pix(input pix_t p, input bit typed, input res_t e);
		step_t s;
		s = '{default: '0};
		s.p = p;
		s.typed = typed;
		s.e = e;
		steps.push_back(s);
	endtask

	// result checker
	initial begin
		res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				n_res++;
				if (mean_q.size() == 0) begin
					report_err("unexpected transfer, col", int'(res.out_col), -1);
				end else begin
					want = mean_q.pop_front();
					if (res.out_col !== want.out_col)
						report_err("out_col", int'(res.out_col), int'(want.out_col));
					if (res.out_row !== want.out_row)
						report_err("out_row", int'(res.out_row), int'(want.out_row));
					if (res.out_red !== want.out_red)
						report_err("out_red", int'(res.out_red), int'(want.out_red));
					if (res.out_green !== want.out_green)
						report_err("out_green", int'(res.out_green), int'(want.out_green));
					if (res.out_blue !== want.out_blue)
						report_err("out_blue", int'(res.out_blue), int'(want.out_blue));
					if (res.run_last !== want.run_last)
						report_err("run_last", int'(res.run_last), int'(want.run_last));
				end
			end
		end
	end

	// receiver stalls: runs of random length
	initial begin
		int left;
		left = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				if (quiet_recv || res_stall) begin
					res_stall = 1'b0;
					left = $urandom_range(1, 30);
				end else begin
					res_stall = 1'b1;
					left = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 3);
				end
			end else begin
				left--;
			end
		end
	end

	// watchdog
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
			if (idle >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", idle);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		res_t e;
		pix_t p;
		int w, h, rand_items;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		errors = 0; n_pix = 0; n_res = 0; n_cfg = 0;
		quiet_send = 1'b0;
		quiet_recv = 1'b0;
		foreach (row_mem[a, b]) row_mem[a][b] = '0;
		pos_col = 0; pos_row = 0;
		reg_w = int'(FW_RST); reg_h = int'(FH_RST); reg_n = int'(WS_RST);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table: single pixel frames read back unchanged, then 2x2 and 3-wide frames
		add_cfg(CFG_FRAME_WIDTH, 13'd1);
		add_cfg(CFG_FRAME_HEIGHT, 13'd1);
		add_cfg(CFG_WINDOW_SIZE, 13'd1);
		add_pix(24'hFF00FF, 1'b1, {10'd0, 12'd0, 8'hFF, 8'h00, 8'hFF, 1'b1});
		add_pix(24'h00FF00, 1'b1, {10'd0, 12'd0, 8'h00, 8'hFF, 8'h00, 1'b1});
		add_cfg(CFG_FRAME_WIDTH, 13'd0);
		add_cfg(CFG_FRAME_HEIGHT, 13'd0);
		add_cfg(CFG_WINDOW_SIZE, 13'd0);
		add_pix(24'h123456, 1'b1, {10'd0, 12'd0, 8'h12, 8'h34, 8'h56, 1'b1});
		add_cfg(CFG_UNUSED, 13'h1FFF);
		add_pix(24'h807F01, 1'b1, {10'd0, 12'd0, 8'h80, 8'h7F, 8'h01, 1'b1});
		add_cfg(CFG_FRAME_WIDTH, 13'd2);
		add_cfg(CFG_FRAME_HEIGHT, 13'd2);
		add_cfg(CFG_WINDOW_SIZE, 13'd2);
		e = '0;
		repeat (3) add_pix(24'hFFFFFF, 1'b0, e);
		add_pix(24'h000000, 1'b0, e);
		add_cfg(CFG_FRAME_WIDTH, 13'd3);
		add_cfg(CFG_WINDOW_SIZE, 13'd8);
		for (int k = 0; k < 6; k++) add_pix(24'hFF0000 >> (4 * k), 1'b0, e);
		foreach (steps[k]) begin
			if (steps[k].is_cfg) write_reg(steps[k].idx, steps[k].data);
			else send_pix(steps[k].p, steps[k].typed, steps[k].e);
		end

		// widest frame, window clamped to its largest size, row cut short by narrowing
		write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
		write_reg(CFG_FRAME_HEIGHT, 13'd1);
		write_reg(CFG_WINDOW_SIZE, 13'h1FFF);
		quiet_recv = 1'b1;
		for (int k = 0; k < 48; k++) begin
			quiet_send = k < 24;
			send_pix(rand_pix(), 1'b0, e);
		end
		quiet_recv = 1'b0;
		quiet_send = 1'b0;
		write_reg(CFG_FRAME_WIDTH, 13'd1);
		send_pix(rand_pix(), 1'b0, e);

		// tallest frame in a single column, cut short by lowering the height
		write_reg(CFG_FRAME_WIDTH, 13'd1);
		write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
		write_reg(CFG_WINDOW_SIZE, 13'd1);
		for (int k = 0; k < 20; k++) send_pix(rand_pix(), 1'b0, e);
		write_reg(CFG_FRAME_HEIGHT, 13'd1);
		send_pix(rand_pix(), 1'b0, e);

		// random frames of small sizes
		rand_items = 0;
		while (rand_items < 240) begin
			w = $urandom_range(0, 4) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12);
			h = $urandom_range(1, 10);
			write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
			write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
			write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'($urandom_range(0, 5) == 0 ?
				$urandom_range(0, 15) : $urandom_range(1, 8)));
			quiet_send = $urandom_range(0, 3) == 0;
			quiet_recv = $urandom_range(0, 3) == 0;
			for (int k = 0; k < w * h; k++) begin
				p = rand_pix();
				send_pix(p, 1'b0, e);
				rand_items++;
			end
		end
		quiet_send = 1'b0;
		pix_valid = 1'b0;

		while (mean_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("%0d pixels and %0d config writes sent, %0d filtered pixels checked",
			n_pix, n_cfg, n_res);
		$display("frames from 1x1 to 40x10, a clamped 1024-wide row and 4096-tall column cut short");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
